/* rtl/kffc_pkg.sv */
// Shared types, constants, key table and microcode program for the keypad calculator.
package kffc_pkg;

    localparam int MaxDigitsDefault = 7;
    localparam int CountWidth       = 3;
    localparam int DataWidth        = 16;
    localparam int PcWidth          = 5;
    localparam int IterWidth        = $clog2(DataWidth);

    localparam logic [7:0] KeyTen     = 8'd10;
    localparam logic [7:0] KeyEquals  = 8'd12;
    localparam logic [7:0] KeyOpFirst = 8'd13;
    localparam logic [7:0] KeyOpLast  = 8'd16;

    localparam logic [2:0] OpNone     = 3'd0;
    localparam logic [2:0] OpAdd      = 3'd1;
    localparam logic [2:0] OpSubtract = 3'd2;
    localparam logic [2:0] OpMultiply = 3'd3;
    localparam logic [2:0] OpDivide   = 3'd4;

    typedef enum logic [1:0] {
        EV_DIGIT    = 2'd0,
        EV_OPERATOR = 2'd1,
        EV_RESULT   = 2'd2,
        EV_IGNORED  = 2'd3
    } event_kind_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_IGNORE,
        DP_DIGIT,
        DP_OPER,
        DP_LOAD,
        DP_MUL,
        DP_DIV,
        DP_DFIX,
        DP_RESULT
    } dp_op_t;

    typedef enum logic [3:0] {
        CD_NEVER,
        CD_ALWAYS,
        CD_NO_XFER,
        CD_DIGIT,
        CD_OPKEY,
        CD_EQKEY,
        CD_FULL,
        CD_PHASE1,
        CD_PHASE0,
        CD_ADDSUB,
        CD_DIV,
        CD_MORE,
        CD_YZERO
    } cond_t;

    typedef struct packed {
        dp_op_t               op;
        cond_t                cond;
        logic [PcWidth-1:0]   target;
    } uword_t;

    localparam logic [PcWidth-1:0] UpcFetch    = 5'd0;
    localparam logic [PcWidth-1:0] UpcIsDigit  = 5'd1;
    localparam logic [PcWidth-1:0] UpcIsOpKey  = 5'd2;
    localparam logic [PcWidth-1:0] UpcIsEquals = 5'd3;
    localparam logic [PcWidth-1:0] UpcIgnore   = 5'd4;
    localparam logic [PcWidth-1:0] UpcDigChk   = 5'd5;
    localparam logic [PcWidth-1:0] UpcDigit    = 5'd6;
    localparam logic [PcWidth-1:0] UpcOpChk    = 5'd7;
    localparam logic [PcWidth-1:0] UpcOper     = 5'd8;
    localparam logic [PcWidth-1:0] UpcEqChk    = 5'd9;
    localparam logic [PcWidth-1:0] UpcLoad     = 5'd10;
    localparam logic [PcWidth-1:0] UpcAddSub   = 5'd11;
    localparam logic [PcWidth-1:0] UpcDivChk   = 5'd12;
    localparam logic [PcWidth-1:0] UpcMulLoop  = 5'd13;
    localparam logic [PcWidth-1:0] UpcMulDone  = 5'd14;
    localparam logic [PcWidth-1:0] UpcZeroChk  = 5'd15;
    localparam logic [PcWidth-1:0] UpcDivLoop  = 5'd16;
    localparam logic [PcWidth-1:0] UpcDivFix   = 5'd17;
    localparam logic [PcWidth-1:0] UpcResult   = 5'd18;

    function automatic logic [7:0] map_key(input logic [7:0] raw);
        logic [7:0] key;
        case (raw)
            8'd6:    key = 8'd1;
            8'd5:    key = 8'd2;
            8'd4:    key = 8'd3;
            8'd3:    key = 8'd13;
            8'd14:   key = 8'd4;
            8'd13:   key = 8'd5;
            8'd12:   key = 8'd6;
            8'd11:   key = 8'd14;
            8'd22:   key = 8'd7;
            8'd21:   key = 8'd8;
            8'd20:   key = 8'd9;
            8'd19:   key = 8'd15;
            8'd30:   key = 8'd11;
            8'd29:   key = 8'd0;
            8'd28:   key = 8'd12;
            8'd27:   key = 8'd16;
            default: key = raw;
        endcase
        return key;
    endfunction

    function automatic uword_t ucode(input logic [PcWidth-1:0] pc);
        uword_t w;
        case (pc)
            UpcFetch:    w = '{DP_NOP,    CD_NO_XFER, UpcFetch};
            UpcIsDigit:  w = '{DP_NOP,    CD_DIGIT,   UpcDigChk};
            UpcIsOpKey:  w = '{DP_NOP,    CD_OPKEY,   UpcOpChk};
            UpcIsEquals: w = '{DP_NOP,    CD_EQKEY,   UpcEqChk};
            UpcIgnore:   w = '{DP_IGNORE, CD_ALWAYS,  UpcFetch};
            UpcDigChk:   w = '{DP_NOP,    CD_FULL,    UpcIgnore};
            UpcDigit:    w = '{DP_DIGIT,  CD_ALWAYS,  UpcFetch};
            UpcOpChk:    w = '{DP_NOP,    CD_PHASE1,  UpcIgnore};
            UpcOper:     w = '{DP_OPER,   CD_ALWAYS,  UpcFetch};
            UpcEqChk:    w = '{DP_NOP,    CD_PHASE0,  UpcIgnore};
            UpcLoad:     w = '{DP_LOAD,   CD_NEVER,   UpcFetch};
            UpcAddSub:   w = '{DP_NOP,    CD_ADDSUB,  UpcResult};
            UpcDivChk:   w = '{DP_NOP,    CD_DIV,     UpcZeroChk};
            UpcMulLoop:  w = '{DP_MUL,    CD_MORE,    UpcMulLoop};
            UpcMulDone:  w = '{DP_NOP,    CD_ALWAYS,  UpcResult};
            UpcZeroChk:  w = '{DP_NOP,    CD_YZERO,   UpcResult};
            UpcDivLoop:  w = '{DP_DIV,    CD_MORE,    UpcDivLoop};
            UpcDivFix:   w = '{DP_DFIX,   CD_ALWAYS,  UpcResult};
            UpcResult:   w = '{DP_RESULT, CD_ALWAYS,  UpcFetch};
            default:     w = '{DP_NOP,    CD_ALWAYS,  UpcFetch};
        endcase
        return w;
    endfunction

endpackage

/* rtl/keypad_four_function_calculator.sv */
// Top level of the keypad calculator: microcoded sequencer and its datapath.
//
// Usage: one raw keypad scan code enters on raw_key per key_valid/key_ready
// transfer; one result item leaves per res_valid/res_ready transfer, with
// event_kind, entry_value, operator_code, result_value and divide_by_zero.
// Each key gives exactly one result item.
// Keys are taken one at a time: key_ready is high only while the sequencer
// sits on its fetch step. The 16-step shift-add multiply loop and the
// 16-step restoring divide loop are the longest paths of the program; a
// divide by zero skips the divide loop. The program runs one micro-step per
// cycle while it does not stall on an output step. The next key is taken
// in the cycle after the result is loaded.
// The result register parts the two sides: a waiting result does not stop
// the next key being taken, but the program holds on its next output step
// until the previous result has been transferred.
// Reset clears the operand, operator, digit count and phase, empties the
// result register and starts the program at its fetch step.
module keypad_four_function_calculator #(
    parameter int MAX_DIGITS = kffc_pkg::MaxDigitsDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        key_valid,
    output logic        key_ready,
    input  logic [7:0]  raw_key,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [1:0]  event_kind,
    output logic signed [15:0] entry_value,
    output logic [2:0]  operator_code,
    output logic signed [15:0] result_value,
    output logic        divide_by_zero
);

    localparam int DW = kffc_pkg::DataWidth;
    localparam int CW = kffc_pkg::CountWidth;
    localparam int PW = kffc_pkg::PcWidth;
    localparam int IW = kffc_pkg::IterWidth;

    kffc_pkg::uword_t uw;

    logic [PW-1:0] pc_reg, pc_next;
    logic          phase_reg, phase_next;
    logic [2:0]    op_reg, op_next;
    logic [DW-1:0] first_reg, first_next;
    logic [DW-1:0] entry_reg, entry_next;
    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg, out_valid_next;

    logic [7:0]    key_reg, key_next;
    logic [DW-1:0] ma_reg, ma_next;
    logic [DW-1:0] mb_reg, mb_next;
    logic [DW-1:0] acc_reg, acc_next;
    logic [IW-1:0] iter_reg, iter_next;
    logic          neg_reg, neg_next;

    logic [1:0]    ev_reg, ev_next;
    logic [DW-1:0] oentry_reg, oentry_next;
    logic [2:0]    oop_reg, oop_next;
    logic [DW-1:0] ores_reg, ores_next;
    logic          odz_reg, odz_next;

    logic          key_xfer;
    logic          emit;
    logic          stall;
    logic          cond_true;
    logic          is_digit, is_opkey, is_eqkey;
    logic [DW:0]   rem_shift;
    logic          rem_ge;
    logic [DW-1:0] answer;
    logic          dz;

    assign uw        = kffc_pkg::ucode(pc_reg);
    assign key_ready = (pc_reg == kffc_pkg::UpcFetch);
    assign key_xfer  = key_valid && key_ready;

    assign is_digit = (key_reg < kffc_pkg::KeyTen);
    assign is_opkey = (key_reg >= kffc_pkg::KeyOpFirst) && (key_reg <= kffc_pkg::KeyOpLast);
    assign is_eqkey = (key_reg == kffc_pkg::KeyEquals);

    assign emit  = (uw.op == kffc_pkg::DP_IGNORE) || (uw.op == kffc_pkg::DP_DIGIT)
                || (uw.op == kffc_pkg::DP_OPER) || (uw.op == kffc_pkg::DP_RESULT);
    assign stall = emit && out_valid_reg && !res_ready;

    assign rem_shift = {acc_reg, ma_reg[DW-1]};
    assign rem_ge    = (rem_shift >= {1'b0, mb_reg});

    always_comb
    begin
        case (uw.cond)
            kffc_pkg::CD_NEVER:   cond_true = 1'b0;
            kffc_pkg::CD_ALWAYS:  cond_true = 1'b1;
            kffc_pkg::CD_NO_XFER: cond_true = !key_xfer;
            kffc_pkg::CD_DIGIT:   cond_true = is_digit;
            kffc_pkg::CD_OPKEY:   cond_true = is_opkey;
            kffc_pkg::CD_EQKEY:   cond_true = is_eqkey;
            kffc_pkg::CD_FULL:    cond_true = (count_reg >= CW'(MAX_DIGITS));
            kffc_pkg::CD_PHASE1:  cond_true = phase_reg;
            kffc_pkg::CD_PHASE0:  cond_true = !phase_reg;
            kffc_pkg::CD_ADDSUB:  cond_true = (op_reg == kffc_pkg::OpAdd)
                                           || (op_reg == kffc_pkg::OpSubtract);
            kffc_pkg::CD_DIV:     cond_true = (op_reg == kffc_pkg::OpDivide);
            kffc_pkg::CD_MORE:    cond_true = (iter_reg != '0);
            kffc_pkg::CD_YZERO:   cond_true = (entry_reg == '0);
            default:              cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        dz = 1'b0;
        case (op_reg)
            kffc_pkg::OpAdd:      answer = first_reg + entry_reg;
            kffc_pkg::OpSubtract: answer = first_reg - entry_reg;
            kffc_pkg::OpMultiply: answer = acc_reg;
            kffc_pkg::OpDivide:
            begin
                dz     = (entry_reg == '0);
                answer = dz ? '0 : acc_reg;
            end
            default:              answer = '0;
        endcase
    end

    always_comb
    begin
        pc_next        = pc_reg;
        phase_next     = phase_reg;
        op_next        = op_reg;
        first_next     = first_reg;
        entry_next     = entry_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        key_next       = key_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        acc_next       = acc_reg;
        iter_next      = iter_reg;
        neg_next       = neg_reg;
        ev_next        = ev_reg;
        oentry_next    = oentry_reg;
        oop_next       = oop_reg;
        ores_next      = ores_reg;
        odz_next       = odz_reg;

        if (out_valid_reg && res_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (key_xfer)
        begin
            key_next = kffc_pkg::map_key(raw_key);
        end

        if (!stall)
        begin
            pc_next = cond_true ? uw.target : pc_reg + PW'(1);

            case (uw.op)
                kffc_pkg::DP_IGNORE:
                begin
                    out_valid_next = 1'b1;
                    ev_next        = kffc_pkg::EV_IGNORED;
                    oentry_next    = entry_reg;
                    oop_next       = op_reg;
                    ores_next      = '0;
                    odz_next       = 1'b0;
                end
                kffc_pkg::DP_DIGIT:
                begin
                    entry_next     = (entry_reg << 3) + (entry_reg << 1) + DW'(key_reg[3:0]);
                    count_next     = count_reg + CW'(1);
                    out_valid_next = 1'b1;
                    ev_next        = kffc_pkg::EV_DIGIT;
                    oentry_next    = (entry_reg << 3) + (entry_reg << 1) + DW'(key_reg[3:0]);
                    oop_next       = op_reg;
                    ores_next      = '0;
                    odz_next       = 1'b0;
                end
                kffc_pkg::DP_OPER:
                begin
                    first_next     = entry_reg;
                    entry_next     = '0;
                    count_next     = '0;
                    op_next        = 3'(key_reg - kffc_pkg::KeyEquals);
                    phase_next     = 1'b1;
                    out_valid_next = 1'b1;
                    ev_next        = kffc_pkg::EV_OPERATOR;
                    oentry_next    = '0;
                    oop_next       = 3'(key_reg - kffc_pkg::KeyEquals);
                    ores_next      = '0;
                    odz_next       = 1'b0;
                end
                kffc_pkg::DP_LOAD:
                begin
                    acc_next  = '0;
                    iter_next = '1;
                    neg_next  = first_reg[DW-1] ^ entry_reg[DW-1];
                    if (op_reg == kffc_pkg::OpDivide)
                    begin
                        ma_next = first_reg[DW-1] ? -first_reg : first_reg;
                        mb_next = entry_reg[DW-1] ? -entry_reg : entry_reg;
                    end
                    else
                    begin
                        ma_next = first_reg;
                        mb_next = entry_reg;
                    end
                end
                kffc_pkg::DP_MUL:
                begin
                    acc_next  = mb_reg[0] ? acc_reg + ma_reg : acc_reg;
                    ma_next   = ma_reg << 1;
                    mb_next   = mb_reg >> 1;
                    iter_next = iter_reg - IW'(1);
                end
                kffc_pkg::DP_DIV:
                begin
                    acc_next  = rem_ge ? DW'(rem_shift - {1'b0, mb_reg}) : rem_shift[DW-1:0];
                    ma_next   = {ma_reg[DW-2:0], rem_ge};
                    iter_next = iter_reg - IW'(1);
                end
                kffc_pkg::DP_DFIX:
                begin
                    acc_next = neg_reg ? -ma_reg : ma_reg;
                end
                kffc_pkg::DP_RESULT:
                begin
                    first_next     = '0;
                    entry_next     = '0;
                    count_next     = '0;
                    op_next        = kffc_pkg::OpNone;
                    phase_next     = 1'b0;
                    out_valid_next = 1'b1;
                    ev_next        = kffc_pkg::EV_RESULT;
                    oentry_next    = '0;
                    oop_next       = kffc_pkg::OpNone;
                    ores_next      = answer;
                    odz_next       = dz;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= kffc_pkg::UpcFetch;
            phase_reg     <= 1'b0;
            op_reg        <= kffc_pkg::OpNone;
            first_reg     <= '0;
            entry_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            phase_reg     <= phase_next;
            op_reg        <= op_next;
            first_reg     <= first_next;
            entry_reg     <= entry_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        acc_reg    <= acc_next;
        iter_reg   <= iter_next;
        neg_reg    <= neg_next;
        ev_reg     <= ev_next;
        oentry_reg <= oentry_next;
        oop_reg    <= oop_next;
        ores_reg   <= ores_next;
        odz_reg    <= odz_next;
    end

    assign res_valid      = out_valid_reg;
    assign event_kind     = ev_reg;
    assign entry_value    = oentry_reg;
    assign operator_code  = oop_reg;
    assign result_value   = ores_reg;
    assign divide_by_zero = odz_reg;

endmodule

/* rtl/kffc_checker.sv */
// Port-level checker for the keypad calculator, bound to the top level.
module kffc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  event_kind,
    input logic signed [15:0] entry_value,
    input logic [2:0]  operator_code,
    input logic signed [15:0] result_value,
    input logic        divide_by_zero
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(event_kind)
            && $stable(entry_value) && $stable(operator_code)
            && $stable(result_value) && $stable(divide_by_zero))
        else $error("result changed while stalled");

    a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && event_kind == kffc_pkg::EV_RESULT
            |-> entry_value == '0 && operator_code == kffc_pkg::OpNone)
        else $error("result left operand or operator pending");

    a_dz_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && divide_by_zero
            |-> event_kind == kffc_pkg::EV_RESULT && result_value == '0)
        else $error("divide-by-zero flag on a non-result or with a value");

    a_no_answer: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && event_kind != kffc_pkg::EV_RESULT |-> result_value == '0 && !divide_by_zero)
        else $error("answer shown without a result");

    a_operator: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && event_kind == kffc_pkg::EV_OPERATOR |-> entry_value == '0
            && operator_code != kffc_pkg::OpNone && operator_code <= kffc_pkg::OpDivide)
        else $error("operator transfer with bad entry or code");

endmodule

bind keypad_four_function_calculator kffc_checker u_kffc_checker (.*);

/* tb/testbench.sv */
// Self-checking testbench for the keypad four-function calculator.
`timescale 1ns / 100ps

module testbench;

    localparam int DigitLimit    = kffc_pkg::MaxDigitsDefault;
    localparam int DecimalBase   = 10;
    localparam int RandomItems   = 1450;
    localparam int WatchdogLimit = 2000;
    localparam int SettleCycles  = 40;

    localparam logic [7:0] ScanEquals = 8'd28;

    localparam logic [7:0] DigitScans [16] = '{
        8'd29, 8'd6, 8'd5, 8'd4, 8'd14, 8'd13, 8'd12, 8'd22,
        8'd21, 8'd20, 8'd0, 8'd1, 8'd2, 8'd7, 8'd8, 8'd9
    };
    localparam logic [7:0] OperatorScans [6] = '{8'd3, 8'd11, 8'd19, 8'd27, 8'd15, 8'd16};

    typedef struct packed {
        kffc_pkg::event_kind_t kind;
        logic [15:0] entry;
        logic [2:0]  op;
        logic [15:0] answer;
        logic        dz;
    } calc_result_t;

    typedef struct packed {
        logic [7:0]   raw;
        logic         typed;
        calc_result_t want;
    } key_step_t;

    localparam key_step_t DirectedSteps [28] = '{
        '{8'd0,   1'b1, '{kffc_pkg::EV_DIGIT,   16'h0000, kffc_pkg::OpNone, 16'h0000, 1'b0}},
        '{8'd255, 1'b1, '{kffc_pkg::EV_IGNORED, 16'h0000, kffc_pkg::OpNone, 16'h0000, 1'b0}},
        '{8'd28,  1'b1, '{kffc_pkg::EV_IGNORED, 16'h0000, kffc_pkg::OpNone, 16'h0000, 1'b0}},
        '{8'd30,  1'b0, '0},
        '{8'd4,   1'b0, '0},
        '{8'd5,   1'b0, '0},
        '{8'd22,  1'b0, '0},
        '{8'd12,  1'b0, '0},
        '{8'd21,  1'b0, '0},
        '{8'd27,  1'b0, '0},
        '{8'd3,   1'b0, '0},
        '{8'd6,   1'b0, '0},
        '{8'd29,  1'b0, '0},
        '{8'd14,  1'b0, '0},
        '{8'd21,  1'b0, '0},
        '{8'd13,  1'b0, '0},
        '{8'd22,  1'b0, '0},
        '{8'd13,  1'b0, '0},
        '{8'd20,  1'b0, '0},
        '{8'd28,  1'b1, '{kffc_pkg::EV_RESULT,  16'h0000, kffc_pkg::OpNone, 16'h8000, 1'b0}},
        '{8'd16,  1'b0, '0},
        '{8'd28,  1'b1, '{kffc_pkg::EV_RESULT,  16'h0000, kffc_pkg::OpNone, 16'h0000, 1'b1}},
        '{8'd3,   1'b0, '0},
        '{8'd28,  1'b0, '0},
        '{8'd11,  1'b0, '0},
        '{8'd28,  1'b0, '0},
        '{8'd15,  1'b0, '0},
        '{8'd28,  1'b0, '0}
    };

    logic               clk;
    logic               rst_n;
    logic               key_valid;
    logic               key_ready;
    logic [7:0]         raw_key;
    logic               res_valid;
    logic               res_ready;
    logic [1:0]         event_kind;
    logic signed [15:0] entry_value;
    logic [2:0]         operator_code;
    logic signed [15:0] result_value;
    logic               divide_by_zero;

    logic               second_phase  = 1'b0;
    logic [2:0]         pending_op    = kffc_pkg::OpNone;
    logic signed [15:0] first_operand = '0;
    logic signed [15:0] entry_acc     = '0;
    logic [2:0]         digits_typed  = '0;

    calc_result_t expected_q [$];
    int           err_count   = 0;
    int           items_taken = 0;
    int           idle_cycles = 0;
    bit           key_burst   = 1'b0;
    bit           res_burst   = 1'b0;

    keypad_four_function_calculator u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .key_valid      (key_valid),
        .key_ready      (key_ready),
        .raw_key        (raw_key),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .event_kind     (event_kind),
        .entry_value    (entry_value),
        .operator_code  (operator_code),
        .result_value   (result_value),
        .divide_by_zero (divide_by_zero)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] scan_to_key(input logic [7:0] raw);
        logic [7:0] key;
        case (raw)
            8'd6:    key = 8'd1;
            8'd5:    key = 8'd2;
            8'd4:    key = 8'd3;
            8'd3:    key = 8'd13;
            8'd14:   key = 8'd4;
            8'd13:   key = 8'd5;
            8'd12:   key = 8'd6;
            8'd11:   key = 8'd14;
            8'd22:   key = 8'd7;
            8'd21:   key = 8'd8;
            8'd20:   key = 8'd9;
            8'd19:   key = 8'd15;
            8'd30:   key = 8'd11;
            8'd29:   key = 8'd0;
            8'd28:   key = 8'd12;
            8'd27:   key = 8'd16;
            default: key = raw;
        endcase
        return key;
    endfunction

    function automatic calc_result_t apply_keypress(input logic [7:0] raw);
        calc_result_t r;
        logic [7:0]   key;
        int           x;
        int           y;
        int           acc;
        key      = scan_to_key(raw);
        r        = '0;
        r.kind   = kffc_pkg::EV_IGNORED;
        if (key < kffc_pkg::KeyTen)
        begin
            if (digits_typed < DigitLimit)
            begin
                entry_acc    = 16'(entry_acc * DecimalBase + key);
                digits_typed = digits_typed + 3'd1;
                r.kind       = kffc_pkg::EV_DIGIT;
            end
        end
        else if (key >= kffc_pkg::KeyOpFirst && key <= kffc_pkg::KeyOpLast)
        begin
            if (!second_phase)
            begin
                first_operand = entry_acc;
                entry_acc     = '0;
                digits_typed  = '0;
                pending_op    = 3'(key - kffc_pkg::KeyEquals);
                second_phase  = 1'b1;
                r.kind        = kffc_pkg::EV_OPERATOR;
            end
        end
        else if (key == kffc_pkg::KeyEquals && second_phase)
        begin
            x   = first_operand;
            y   = entry_acc;
            acc = 0;
            case (pending_op)
                kffc_pkg::OpAdd:      acc = x + y;
                kffc_pkg::OpSubtract: acc = x - y;
                kffc_pkg::OpMultiply: acc = x * y;
                kffc_pkg::OpDivide:
                begin
                    if (y == 0)
                        r.dz = 1'b1;
                    else
                        acc = x / y;
                end
                default:    acc = 0;
            endcase
            r.answer      = acc[15:0];
            first_operand = '0;
            entry_acc     = '0;
            digits_typed  = '0;
            pending_op    = kffc_pkg::OpNone;
            second_phase  = 1'b0;
            r.kind        = kffc_pkg::EV_RESULT;
        end
        r.entry = entry_acc;
        r.op    = pending_op;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic send_key(input logic [7:0] raw, input logic typed = 1'b0,
                            input calc_result_t want = '0);
        int           gap;
        calc_result_t predicted;
        if ($urandom_range(0, 29) == 0)
            key_burst = ~key_burst;
        gap = key_burst ? 0 : $urandom_range(0, 11);
        repeat (gap)
        begin
            @(negedge clk);
            key_valid <= 1'b0;
        end
        @(negedge clk);
        key_valid <= 1'b1;
        raw_key   <= raw;
        do
            @(posedge clk);
        while (!key_ready);
        predicted = apply_keypress(raw);
        expected_q.push_back(typed ? want : predicted);
        items_taken++;
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_digit();
        return DigitScans[$urandom_range(0, 15)];
    endfunction

    function automatic int pick_length();
        return ($urandom_range(0, 11) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 5);
    endfunction

    task automatic maybe_noise();
        if ($urandom_range(0, 7) == 0)
            send_key(8'($urandom_range(0, 255)));
    endtask

    task automatic play_calculation();
        int n;
        n = pick_length();
        repeat (n) send_key(pick_digit());
        maybe_noise();
        if ($urandom_range(0, 9) != 0)
            send_key(OperatorScans[$urandom_range(0, 5)]);
        maybe_noise();
        n = pick_length();
        repeat (n) send_key(pick_digit());
        maybe_noise();
        if ($urandom_range(0, 9) != 0)
            send_key(ScanEquals);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        key_valid = 1'b0;
        raw_key   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (DirectedSteps[i])
            send_key(DirectedSteps[i].raw, DirectedSteps[i].typed, DirectedSteps[i].want);
        @(negedge clk);
        key_valid <= 1'b0;
        wait_drained();
        items_taken = 0;
        while (items_taken < RandomItems)
        begin
            play_calculation();
            if ($urandom_range(0, 59) == 0)
            begin
                @(negedge clk);
                key_valid <= 1'b0;
                wait_drained();
            end
        end
        @(negedge clk);
        key_valid <= 1'b0;
        wait_drained();
        repeat (SettleCycles) @(posedge clk);
        if (err_count == 0)
            $display("keypad_four_function_calculator regression: pass");
        else
            $display("keypad_four_function_calculator regression: fail");
        $finish;
    end

    initial
    begin
        int           stall;
        calc_result_t exp_item;
        res_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                res_burst = ~res_burst;
            stall = res_burst ? 0 : $urandom_range(0, 11);
            repeat (stall)
            begin
                @(negedge clk);
                res_ready <= 1'b0;
            end
            @(negedge clk);
            res_ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_valid);
            if (expected_q.size() == 0)
                report_mismatch("result transfer with nothing expected");
            else
            begin
                exp_item = expected_q.pop_front();
                if (event_kind !== exp_item.kind)
                    report_mismatch($sformatf("event_kind %0d, want %0d",
                                              event_kind, exp_item.kind));
                if (entry_value !== exp_item.entry)
                    report_mismatch($sformatf("entry_value %0d, want %0d",
                                              entry_value, $signed(exp_item.entry)));
                if (operator_code !== exp_item.op)
                    report_mismatch($sformatf("operator_code %0d, want %0d",
                                              operator_code, exp_item.op));
                if (result_value !== exp_item.answer)
                    report_mismatch($sformatf("result_value %0d, want %0d",
                                              result_value, $signed(exp_item.answer)));
                if (divide_by_zero !== exp_item.dz)
                    report_mismatch($sformatf("divide_by_zero %0b, want %0b",
                                              divide_by_zero, exp_item.dz));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (key_valid && key_ready) || (res_valid && res_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WatchdogLimit)
        begin
            $display("keypad_four_function_calculator regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
